FILE: hw/rtl/mpdf_pkg.sv
// Shared types and constants for the modem payload deframer.
package mpdf_pkg;

    localparam int unsigned HDR_LEN = 9;

    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        PH_SEARCH = 4'b0001,
        PH_SKIP   = 4'b0010,
        PH_LEN    = 4'b0100,
        PH_DATA   = 4'b1000
    } phase_t;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic pop_hit;
        logic dropped;
        logic pkt_end;
    } res_t;

    function automatic logic [7:0] hdr_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = 8'h2B;
            4'd1:    ch = 8'h4D;
            4'd2:    ch = 8'h49;
            4'd3:    ch = 8'h50;
            4'd4:    ch = 8'h52;
            4'd5:    ch = 8'h54;
            4'd6:    ch = 8'h43;
            4'd7:    ch = 8'h50;
            4'd8:    ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: hw/rtl/mpdf_parser.sv
// Header/length parser and ring buffer pointer control.
module mpdf_parser #(
    parameter int BUF_DEPTH  = 8192,
    parameter int LEN_BITS   = 16,
    parameter int MAX_DIGITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [1:0]                   req_type,
    input  logic [7:0]                   byte_in,
    output logic                         wr_en,
    output logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
    output logic [$clog2(BUF_DEPTH)-1:0] rd_addr,
    output mpdf_pkg::res_t               res
);

    localparam int PTR_W = $clog2(BUF_DEPTH);
    localparam int DC_W  = $clog2(MAX_DIGITS + 1);
    localparam int EXT_W = LEN_BITS + 4;
    localparam logic [PTR_W-1:0]    PTR_LAST = PTR_W'(BUF_DEPTH - 1);
    localparam logic [LEN_BITS-1:0] LEN_MAX  = {LEN_BITS{1'b1}};

    mpdf_pkg::phase_t    phase_reg, phase_next;
    logic [3:0]          hpos_reg, hpos_next;
    logic [LEN_BITS-1:0] acc_reg, acc_next;
    logic [DC_W-1:0]     dcnt_reg, dcnt_next;
    logic [LEN_BITS-1:0] rem_reg, rem_next;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [PTR_W-1:0]    rp_reg, rp_next;

    logic [PTR_W-1:0]    wp_inc, rp_inc;
    logic [EXT_W-1:0]    acc_ext, prod;
    logic [LEN_BITS-1:0] rem_dec;
    logic                is_digit;

    assign wp_inc   = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
    assign rp_inc   = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
    assign acc_ext  = EXT_W'(acc_reg);
    assign prod     = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(byte_in - mpdf_pkg::CHAR_ZERO);
    assign is_digit = (byte_in >= mpdf_pkg::CHAR_ZERO) && (byte_in <= mpdf_pkg::CHAR_NINE);
    assign rem_dec  = rem_reg - 1'b1;

    assign wr_addr = wp_reg;
    assign rd_addr = rp_reg;

    always_comb
    begin
        phase_next = phase_reg;
        hpos_next  = hpos_reg;
        acc_next   = acc_reg;
        dcnt_next  = dcnt_reg;
        rem_next   = rem_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        wr_en      = 1'b0;
        res        = '0;
        unique case (mpdf_pkg::req_t'(req_type))
            mpdf_pkg::REQ_BYTE:
            begin
                unique case (phase_reg)
                    mpdf_pkg::PH_SEARCH:
                    begin
                        if ((hpos_reg < 4'(mpdf_pkg::HDR_LEN))
                            && (byte_in == mpdf_pkg::hdr_char(hpos_reg)))
                        begin
                            if (hpos_reg == 4'(mpdf_pkg::HDR_LEN - 1))
                            begin
                                phase_next = mpdf_pkg::PH_SKIP;
                                hpos_next  = '0;
                            end
                            else
                            begin
                                hpos_next = hpos_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            hpos_next = (byte_in == mpdf_pkg::CHAR_PLUS) ? 4'd1 : 4'd0;
                        end
                    end
                    mpdf_pkg::PH_SKIP:
                    begin
                        if (byte_in == mpdf_pkg::CHAR_COMMA)
                        begin
                            phase_next = mpdf_pkg::PH_LEN;
                            acc_next   = '0;
                            dcnt_next  = '0;
                        end
                    end
                    mpdf_pkg::PH_LEN:
                    begin
                        if (byte_in == mpdf_pkg::CHAR_COMMA)
                        begin
                            if (acc_reg != '0)
                            begin
                                rem_next   = acc_reg;
                                phase_next = mpdf_pkg::PH_DATA;
                            end
                            else
                            begin
                                phase_next = mpdf_pkg::PH_SEARCH;
                                hpos_next  = '0;
                            end
                        end
                        else if (is_digit && (dcnt_reg < DC_W'(MAX_DIGITS)))
                        begin
                            acc_next  = (prod[EXT_W-1:LEN_BITS] != '0) ? LEN_MAX
                                                                      : prod[LEN_BITS-1:0];
                            dcnt_next = dcnt_reg + 1'b1;
                        end
                    end
                    mpdf_pkg::PH_DATA:
                    begin
                        if (rem_reg != '0)
                        begin
                            if (wp_inc != rp_reg)
                            begin
                                wr_en   = 1'b1;
                                wp_next = wp_inc;
                            end
                            else
                            begin
                                res.dropped = 1'b1;
                            end
                            rem_next    = rem_dec;
                            res.pkt_end = (rem_dec == '0);
                        end
                        if ((rem_reg == '0) || (rem_dec == '0))
                        begin
                            phase_next = mpdf_pkg::PH_SEARCH;
                            hpos_next  = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = mpdf_pkg::PH_SEARCH;
                    end
                endcase
            end
            mpdf_pkg::REQ_POP:
            begin
                if (rp_reg != wp_reg)
                begin
                    res.pop_hit = 1'b1;
                    rp_next     = rp_inc;
                end
            end
            mpdf_pkg::REQ_FLUSH:
            begin
                phase_next = mpdf_pkg::PH_SEARCH;
                hpos_next  = '0;
                acc_next   = '0;
                dcnt_next  = '0;
                rem_next   = '0;
                wp_next    = '0;
                rp_next    = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mpdf_pkg::PH_SEARCH;
            hpos_reg  <= '0;
            acc_reg   <= '0;
            dcnt_reg  <= '0;
            rem_reg   <= '0;
            wp_reg    <= '0;
            rp_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            acc_reg   <= acc_next;
            dcnt_reg  <= dcnt_next;
            rem_reg   <= rem_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
        end
    end

endmodule

FILE: hw/rtl/modem_payload_deframer_fifo_top.sv
// Top level of the modem payload deframer with its payload ring buffer.
// Usage:
//   Input channel (in_valid/in_ready) carries one request item: req_type
//   0 delivers a serial byte in byte_in, 1 pops one buffered payload byte,
//   2 flushes the parser and empties the buffer, 3 does nothing.
//   Output channel (out_valid/out_ready) returns exactly one result item per
//   request, in order: popped_byte/popped_valid for pops, byte_dropped when
//   a payload byte hit a full buffer, packet_end on the last payload byte.
//   The result of an item passes through the read stage (synchronous buffer
//   read) and the output register before it is offered.
//   Throughput: one item per cycle while the receiver does not stall, set by
//   the registered parser update and one buffer read, at most one write, per item.
//   When the receiver stalls, one result waits in the output register and a
//   second in the read stage; in_ready drops only when both are occupied.
//   Reset clears the parser, pointers and pipeline at once; the buffer
//   contents are not cleared and no clearing pass is needed.
//   The buffer holds at most BUF_DEPTH-1 bytes.
module modem_payload_deframer_fifo_top #(
    parameter int BUF_DEPTH  = 8192,
    parameter int LEN_BITS   = 16,
    parameter int MAX_DIGITS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] popped_byte,
    output logic       popped_valid,
    output logic       byte_dropped,
    output logic       packet_end
);

    localparam int PTR_W = $clog2(BUF_DEPTH);

    logic             accept;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr, rd_addr;
    mpdf_pkg::res_t   res;

    logic [7:0]       mem [BUF_DEPTH];
    logic [7:0]       mem_q;

    logic             s1_valid_reg, s1_valid_next;
    mpdf_pkg::res_t   s1_res_reg;
    logic             s1_adv;

    logic             ov_reg, ov_next;
    mpdf_pkg::res_t   o_res_reg;
    logic [7:0]       o_byte_reg;

    assign s1_adv   = s1_valid_reg && (!ov_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    mpdf_parser #(
        .BUF_DEPTH  (BUF_DEPTH),
        .LEN_BITS   (LEN_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (req_type),
        .byte_in  (byte_in),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .res      (res)
    );

    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            mem[wr_addr] <= byte_in;
        end
        if (accept)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    assign s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign ov_next       = s1_adv ? 1'b1 : ((ov_reg && out_ready) ? 1'b0 : ov_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
        end
        if (s1_adv)
        begin
            o_res_reg  <= s1_res_reg;
            o_byte_reg <= s1_res_reg.pop_hit ? mem_q : 8'h00;
        end
    end

    assign out_valid    = ov_reg;
    assign popped_byte  = o_byte_reg;
    assign popped_valid = o_res_reg.pop_hit;
    assign byte_dropped = o_res_reg.dropped;
    assign packet_end   = o_res_reg.pkt_end;

`ifndef SYNTHESIS
    a_wr_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && wr_en) |=> (u_parser.wr_addr != u_parser.rd_addr))
        else $error("buffer write made pointers collide");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("read stage result lost under stall");

    a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !popped_valid) |-> (popped_byte == 8'h00))
        else $error("popped_byte nonzero without a pop hit");

    a_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.pop_hit) |-> (!wr_en && !res.dropped && !res.pkt_end))
        else $error("pop result mixed with byte result");
`endif

endmodule

FILE: tb/tb.sv
// Testbench for the modem payload deframer: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import mpdf_pkg::*;

    localparam int BUF_DEPTH  = 8192;
    localparam int LEN_BITS   = 16;
    localparam int MAX_DIGITS = 10;
    localparam int LEN_MAX    = (1 << LEN_BITS) - 1;
    localparam int LATENCY    = 2;
    localparam logic [71:0] HDR_STR = "+MIPRTCP:";

    typedef struct packed {
        logic [7:0] data;
        logic       hit;
        logic       drop;
        logic       last;
    } deframe_res_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] req_type;
    logic [7:0] byte_in;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] popped_byte;
    logic       popped_valid;
    logic       byte_dropped;
    logic       packet_end;

    modem_payload_deframer_fifo_top #(
        .BUF_DEPTH  (BUF_DEPTH),
        .LEN_BITS   (LEN_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .byte_in      (byte_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .popped_byte  (popped_byte),
        .popped_valid (popped_valid),
        .byte_dropped (byte_dropped),
        .packet_end   (packet_end)
    );

    // predictor state
    phase_t      m_phase;
    int unsigned m_hpos;
    int unsigned m_len;
    int unsigned m_digits;
    int unsigned m_remain;
    logic [7:0]  m_store [BUF_DEPTH];
    logic [12:0] m_wr;
    logic [12:0] m_rd;

    deframe_res_t pending_results[$];
    int           n_errors;
    int           n_sent;
    int           burst_left;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    task automatic clear_parser();
        m_phase  = PH_SEARCH;
        m_hpos   = 0;
        m_len    = 0;
        m_digits = 0;
        m_remain = 0;
        m_wr     = '0;
        m_rd     = '0;
    endtask

    task automatic deframe_step(input req_t rq, input logic [7:0] b, output deframe_res_t r);
        int unsigned v;
        logic [12:0] nxt;
        r = '0;
        case (rq)
            REQ_BYTE: begin
                case (m_phase)
                    PH_SEARCH: begin
                        if (m_hpos < HDR_LEN && b == HDR_STR[71 - 8 * m_hpos -: 8]) begin
                            m_hpos++;
                            if (m_hpos == HDR_LEN) begin
                                m_phase = PH_SKIP;
                                m_hpos  = 0;
                            end
                        end else begin
                            m_hpos = (b == CHAR_PLUS) ? 1 : 0;
                        end
                    end
                    PH_SKIP: begin
                        if (b == CHAR_COMMA) begin
                            m_phase  = PH_LEN;
                            m_len    = 0;
                            m_digits = 0;
                        end
                    end
                    PH_LEN: begin
                        if (b == CHAR_COMMA) begin
                            if (m_len > 0) begin
                                m_remain = m_len;
                                m_phase  = PH_DATA;
                            end else begin
                                m_phase = PH_SEARCH;
                                m_hpos  = 0;
                            end
                        end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                            if (m_digits < MAX_DIGITS) begin
                                v = m_len * 10 + (int'(b) - int'(CHAR_ZERO));
                                m_len = (v > LEN_MAX) ? LEN_MAX : v;
                                m_digits++;
                            end
                        end
                    end
                    default: begin
                        if (m_remain > 0) begin
                            nxt = m_wr + 13'd1;
                            if (nxt != m_rd) begin
                                m_store[m_wr] = b;
                                m_wr = nxt;
                            end else begin
                                r.drop = 1'b1;
                            end
                            m_remain--;
                            if (m_remain == 0)
                                r.last = 1'b1;
                        end
                        if (m_remain == 0) begin
                            m_phase = PH_SEARCH;
                            m_hpos  = 0;
                        end
                    end
                endcase
            end
            REQ_POP: begin
                if (m_rd != m_wr) begin
                    r.data = m_store[m_rd];
                    r.hit  = 1'b1;
                    m_rd   = m_rd + 13'd1;
                end
            end
            REQ_FLUSH: clear_parser();
            default: ;
        endcase
    endtask

    task automatic send_item(input req_t rq, input logic [7:0] b);
        deframe_res_t r;
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        req_type <= rq;
        byte_in  <= b;
        do @(posedge clk); while (!in_ready);
        deframe_step(rq, b, r);
        pending_results.push_back(r);
        n_sent++;
        burst_left--;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(REQ_BYTE, s[i]);
    endtask

    task automatic pop_n(input int n);
        repeat (n) send_item(REQ_POP, 8'h00);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // header, id, length field, payload; pops mixed in at pop_pct percent
    task automatic send_packet(input int len, input int pop_pct);
        int n_id;
        send_text("+MIPRTCP:");
        n_id = $urandom_range(0, 3);
        repeat (n_id) send_item(REQ_BYTE, 8'h30 + 8'($urandom_range(0, 9)));
        send_item(REQ_BYTE, CHAR_COMMA);
        send_text($sformatf("%0d,", len));
        repeat (len) begin
            if ($urandom_range(1, 100) <= pop_pct)
                send_item(REQ_POP, 8'h00);
            send_item(REQ_BYTE, 8'($urandom));
        end
    endtask

    task automatic test_basic_packet();
        send_text("+MIPRTCP:7,3,");
        send_item(REQ_BYTE, 8'h00);
        send_item(REQ_BYTE, 8'hFF);
        send_item(REQ_BYTE, 8'hA5);
        pop_n(4);
        send_item(REQ_NONE, 8'hFF);
    endtask

    task automatic test_header_restart();
        send_text("++MIP+MIPRTCP:x,1a,");
        send_item(REQ_BYTE, 8'h5A);
        pop_n(2);
    endtask

    task automatic test_length_cases();
        send_text("+MIPRTCP:1,0,");
        send_text("+MIPRTCP:1,000000000012,Q");
        pop_n(1);
        send_text("+MIPRTCP:1,99999,ab");
        send_item(REQ_FLUSH, 8'h00);
        pop_n(1);
        send_text("+MIPRTCP:1,70000,z");
        send_item(REQ_FLUSH, 8'h00);
    endtask

    task automatic test_flush();
        send_text("+MIP");
        send_item(REQ_FLUSH, 8'h2B);
        send_text("RTCP:1,1,X");
        pop_n(1);
        send_text("+MIPRTCP:1,2,ST");
        send_item(REQ_FLUSH, 8'h00);
        pop_n(1);
    endtask

    task automatic test_random();
        int stop_at;
        int sel;
        int len;
        int cut;
        string hdr;
        stop_at = n_sent + 300;
        while (n_sent < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                len = ($urandom_range(0, 19) == 0) ? 0
                    : ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                    : $urandom_range(1, 12);
                send_packet(len, 30);
            end else if (sel < 72) begin
                // broken header, then random header characters
                hdr = "+MIPRTCP:";
                cut = $urandom_range(1, HDR_LEN - 1);
                for (int i = 0; i < cut; i++)
                    send_item(REQ_BYTE, hdr[i]);
                send_item(REQ_BYTE, ($urandom_range(0, 1) == 0) ? CHAR_PLUS : 8'($urandom));
                repeat ($urandom_range(0, 6))
                    send_item(REQ_BYTE, hdr[$urandom_range(0, HDR_LEN - 1)]);
            end else if (sel < 85) begin
                pop_n($urandom_range(1, 20));
            end else if (sel < 93) begin
                repeat ($urandom_range(1, 5)) send_item(REQ_BYTE, 8'($urandom));
            end else if (sel < 97) begin
                send_item(REQ_NONE, 8'($urandom));
            end else begin
                send_item(REQ_FLUSH, 8'($urandom));
            end
        end
        pop_n(40);
    endtask

    // receiver stall pattern
    int rx_mode;
    int rx_count;
    int rx_hold;
    always @(negedge clk) begin
        if (rx_count == 0) begin
            rx_mode  <= $urandom_range(0, 3);
            rx_count <= $urandom_range(50, 200);
        end else begin
            rx_count <= rx_count - 1;
        end
        if (rx_hold > 0) begin
            rx_hold   <= rx_hold - 1;
            out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= (rx_count % 5 != 0);
                default: begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        rx_hold <= $urandom_range(1, 20);
                end
            endcase
        end
    end

    always @(posedge clk) begin
        deframe_res_t e;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected result item: byte=%h valid=%b drop=%b end=%b",
                             popped_byte, popped_valid, byte_dropped, packet_end);
            end else begin
                e = pending_results.pop_front();
                if (popped_byte !== e.data || popped_valid !== e.hit ||
                    byte_dropped !== e.drop || packet_end !== e.last) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"ERROR: exp byte=%h valid=%b drop=%b end=%b, ",
                                  "got byte=%h valid=%b drop=%b end=%b"},
                                 e.data, e.hit, e.drop, e.last,
                                 popped_byte, popped_valid, byte_dropped, packet_end);
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = REQ_BYTE;
        byte_in    = 8'h00;
        out_ready  = 1'b0;
        rx_mode    = 0;
        rx_count   = 0;
        rx_hold    = 0;
        n_errors   = 0;
        n_sent     = 0;
        burst_left = 0;
        clear_parser();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_packet();
        test_header_restart();
        wait_idle();
        test_length_cases();
        test_flush();
        wait_idle();
        test_random();

        wait_idle();
        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/mpdf_pkg.sv
hw/rtl/mpdf_parser.sv
hw/rtl/modem_payload_deframer_fifo_top.sv
tb/tb.sv
